// ===== sv/tea_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and register codes of the TEA block cipher.
// Depends on nothing; every other file of the block uses it.
package tea_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int ROUND_COUNT_DEFAULT = 32;

   localparam logic [WORD_WIDTH-1:0] TEA_DELTA = 32'h9E3779B9;

   localparam logic [WORD_WIDTH-1:0] KEY_WORD_ZERO_RESET = 32'h4DD87487;
   localparam logic [WORD_WIDTH-1:0] KEY_WORD_ONE_RESET = 32'hC15011B0;
   localparam logic [WORD_WIDTH-1:0] KEY_WORD_TWO_RESET = 32'h5EDD6B3D;
   localparam logic [WORD_WIDTH-1:0] KEY_WORD_THREE_RESET = 32'h43CF5892;
   localparam logic COMPLEMENT_MODE_RESET = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_ZERO = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_ONE = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_TWO = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_THREE = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COMPLEMENT_MODE = 3'd4;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] k0;
      logic [WORD_WIDTH-1:0] k1;
      logic [WORD_WIDTH-1:0] k2;
      logic [WORD_WIDTH-1:0] k3;
   } key_type;

   typedef struct packed {
      logic                  valid;
      logic                  cmd;
      logic [WORD_WIDTH-1:0] left;
      logic [WORD_WIDTH-1:0] right;
      logic                  last;
   } stage_type;

endpackage
`default_nettype wire

// ===== sv/tea_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Input channel of the TEA block cipher: one block and its command per item.
// Depends on tea_pkg for the word width.
interface tea_req_if;
   logic                           valid;
   logic                           ready;
   logic                           cmd;
   logic [tea_pkg::WORD_WIDTH-1:0] word_left;
   logic [tea_pkg::WORD_WIDTH-1:0] word_right;
   logic                           last_block;

   modport source (output valid, cmd, word_left, word_right, last_block, input ready);
   modport sink (input valid, cmd, word_left, word_right, last_block, output ready);
endinterface
`default_nettype wire

// ===== sv/tea_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Result channel of the TEA block cipher: one result block per item.
// Depends on tea_pkg for the word width.
interface tea_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tea_pkg::WORD_WIDTH-1:0] out_left;
   logic [tea_pkg::WORD_WIDTH-1:0] out_right;
   logic                           last_block_out;

   modport source (output valid, out_left, out_right, last_block_out, input ready);
   modport sink (input valid, out_left, out_right, last_block_out, output ready);
endinterface
`default_nettype wire

// ===== sv/tea_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One half of a TEA cycle with its stage register, a link of the cell chain.
// Depends on tea_pkg for the stage and key types and the round constant.
module tea_cell #(
   parameter int ROUND_COUNT = tea_pkg::ROUND_COUNT_DEFAULT,
   parameter int ROUND_INDEX = 0,
   parameter bit SECOND_HALF = 1'b0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire tea_pkg::key_type   key,
   input  wire tea_pkg::stage_type stage_in,
   output tea_pkg::stage_type      stage_out
);

   localparam logic [tea_pkg::WORD_WIDTH-1:0] ENC_SUM =
      tea_pkg::WORD_WIDTH'(tea_pkg::TEA_DELTA * (ROUND_INDEX + 1));
   localparam logic [tea_pkg::WORD_WIDTH-1:0] DEC_SUM =
      tea_pkg::WORD_WIDTH'(tea_pkg::TEA_DELTA * (ROUND_COUNT - ROUND_INDEX));

   tea_pkg::stage_type stage_ff;
   tea_pkg::stage_type stage_in_next;

   logic                           encrypt;
   logic                           update_left;
   logic [tea_pkg::WORD_WIDTH-1:0] src;
   logic [tea_pkg::WORD_WIDTH-1:0] dst;
   logic [tea_pkg::WORD_WIDTH-1:0] ka;
   logic [tea_pkg::WORD_WIDTH-1:0] kb;
   logic [tea_pkg::WORD_WIDTH-1:0] sum;
   logic [tea_pkg::WORD_WIDTH-1:0] mix;
   logic [tea_pkg::WORD_WIDTH-1:0] result;

   // Encryption updates the left word first, decryption the right word first.
   always_comb begin
      encrypt = (stage_in.cmd == tea_pkg::CMD_ENCRYPT);
      update_left = (encrypt != SECOND_HALF);
      src = update_left ? stage_in.right : stage_in.left;
      dst = update_left ? stage_in.left : stage_in.right;
      ka = update_left ? key.k0 : key.k2;
      kb = update_left ? key.k1 : key.k3;
      sum = encrypt ? ENC_SUM : DEC_SUM;
      mix = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
      result = encrypt ? (dst + mix) : (dst - mix);
      stage_in_next = stage_in;
      if (update_left) begin
         stage_in_next.left = result;
      end else begin
         stage_in_next.right = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (enable) begin
         stage_ff.cmd <= stage_in_next.cmd;
         stage_ff.left <= stage_in_next.left;
         stage_ff.right <= stage_in_next.right;
         stage_ff.last <= stage_in_next.last;
      end
   end

   assign stage_out = stage_ff;

endmodule
`default_nettype wire

// ===== sv/tea_block_cipher.sv =====
// Path of an accepted item to its result: one cell per half cycle, then the
// output register.
// Throughput: one item per cycle; the whole cell chain advances together and
// holds only while a result waits at the output and the sink is not ready.
// Reset clears all valid flags and loads the key and complement registers
// with their defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
// Top level of the TEA block cipher: configuration registers and cell chain.
// Depends on tea_pkg, tea_req_if, tea_rsp_if and tea_cell.
module tea_block_cipher #(
   parameter int ROUND_COUNT = tea_pkg::ROUND_COUNT_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   tea_req_if.sink                                  req_if,
   tea_rsp_if.source                                rsp_if,
   input  wire logic                                csr_write_en,
   input  wire logic [tea_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [tea_pkg::WORD_WIDTH-1:0]      csr_data
);

   localparam int CELL_COUNT = 2 * ROUND_COUNT;

   tea_pkg::key_type   key_ff;
   logic               complement_ff;
   tea_pkg::stage_type rsp_ff;
   tea_pkg::stage_type rsp_in;
   tea_pkg::stage_type chain [0:CELL_COUNT];
   logic               enable;
   logic               invert_in;
   logic               invert_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff.k0 <= tea_pkg::KEY_WORD_ZERO_RESET;
         key_ff.k1 <= tea_pkg::KEY_WORD_ONE_RESET;
         key_ff.k2 <= tea_pkg::KEY_WORD_TWO_RESET;
         key_ff.k3 <= tea_pkg::KEY_WORD_THREE_RESET;
         complement_ff <= tea_pkg::COMPLEMENT_MODE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            tea_pkg::CSR_KEY_WORD_ZERO:   key_ff.k0 <= csr_data;
            tea_pkg::CSR_KEY_WORD_ONE:    key_ff.k1 <= csr_data;
            tea_pkg::CSR_KEY_WORD_TWO:    key_ff.k2 <= csr_data;
            tea_pkg::CSR_KEY_WORD_THREE:  key_ff.k3 <= csr_data;
            tea_pkg::CSR_COMPLEMENT_MODE: complement_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign enable = !rsp_ff.valid || rsp_if.ready;
   assign req_if.ready = enable && !reset;

   // With complement mode set, the ciphertext side is inverted before decryption and after encryption.
   always_comb begin
      invert_in = complement_ff && (req_if.cmd == tea_pkg::CMD_DECRYPT);
      chain[0].valid = req_if.valid;
      chain[0].cmd = req_if.cmd;
      chain[0].left = invert_in ? ~req_if.word_left : req_if.word_left;
      chain[0].right = invert_in ? ~req_if.word_right : req_if.word_right;
      chain[0].last = req_if.last_block;
   end

   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      tea_cell #(
         .ROUND_COUNT (ROUND_COUNT),
         .ROUND_INDEX (i / 2),
         .SECOND_HALF (1'((i % 2) != 0))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .key       (key_ff),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   always_comb begin
      invert_out = complement_ff && (chain[CELL_COUNT].cmd == tea_pkg::CMD_ENCRYPT);
      rsp_in = chain[CELL_COUNT];
      rsp_in.left = invert_out ? ~chain[CELL_COUNT].left : chain[CELL_COUNT].left;
      rsp_in.right = invert_out ? ~chain[CELL_COUNT].right : chain[CELL_COUNT].right;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else if (enable) begin
         rsp_ff.valid <= rsp_in.valid;
      end
      if (enable) begin
         rsp_ff.cmd <= rsp_in.cmd;
         rsp_ff.left <= rsp_in.left;
         rsp_ff.right <= rsp_in.right;
         rsp_ff.last <= rsp_in.last;
      end
   end

   assign rsp_if.valid = rsp_ff.valid;
   assign rsp_if.out_left = rsp_ff.left;
   assign rsp_if.out_right = rsp_ff.right;
   assign rsp_if.last_block_out = rsp_ff.last;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tea_block_cipher: blocks are driven under several keys,
// complement settings and flow patterns, and each result is compared with a local TEA model.
// Depends on tea_pkg, tea_req_if and tea_rsp_if from the RTL.
module tb;
   import tea_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 2 * ROUND_COUNT_DEFAULT + 16;
   localparam int PHASE_ITEMS = 330;
   localparam int PRINT_LIMIT = 25;

   typedef struct packed {
      logic                  cmd;
      logic [WORD_WIDTH-1:0] left;
      logic [WORD_WIDTH-1:0] right;
      logic                  last;
   } block_item;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] left;
      logic [WORD_WIDTH-1:0] right;
      logic                  last;
   } cipher_block;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [WORD_WIDTH-1:0]      csr_data;

   tea_req_if req_ch ();
   tea_rsp_if rsp_ch ();

   tea_block_cipher u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   key_type     model_key;
   logic        model_complement;
   block_item   blocks_to_send[$];
   cipher_block expected_blocks[$];
   int          send_idle_pct;
   int          recv_stall_pct;
   int          blocks_sent;
   int          blocks_checked;
   int          error_count;
   int          cycle_count;
   int          setting_count;

   always #4 clock = ~clock;

   function automatic logic [WORD_WIDTH-1:0] tea_mix(input logic [WORD_WIDTH-1:0] x,
                                                     input logic [WORD_WIDTH-1:0] sum,
                                                     input logic [WORD_WIDTH-1:0] ka,
                                                     input logic [WORD_WIDTH-1:0] kb);
      return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
   endfunction

   function automatic cipher_block tea_transform(input block_item blk);
      cipher_block           res;
      logic [WORD_WIDTH-1:0] y;
      logic [WORD_WIDTH-1:0] z;
      logic [WORD_WIDTH-1:0] sum;
      y = blk.left;
      z = blk.right;
      if (blk.cmd == CMD_ENCRYPT) begin
         sum = '0;
         for (int i = 0; i < ROUND_COUNT_DEFAULT; i++) begin
            sum = sum + TEA_DELTA;
            y = y + tea_mix(z, sum, model_key.k0, model_key.k1);
            z = z + tea_mix(y, sum, model_key.k2, model_key.k3);
         end
         if (model_complement) begin
            y = ~y;
            z = ~z;
         end
      end else begin
         if (model_complement) begin
            y = ~y;
            z = ~z;
         end
         sum = TEA_DELTA * 32'(ROUND_COUNT_DEFAULT);
         for (int i = 0; i < ROUND_COUNT_DEFAULT; i++) begin
            z = z - tea_mix(y, sum, model_key.k2, model_key.k3);
            y = y - tea_mix(z, sum, model_key.k0, model_key.k1);
            sum = sum - TEA_DELTA;
         end
      end
      res.left = y;
      res.right = z;
      res.last = blk.last;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      error_count++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [WORD_WIDTH-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      case (idx)
         CSR_KEY_WORD_ZERO: model_key.k0 = data;
         CSR_KEY_WORD_ONE: model_key.k1 = data;
         CSR_KEY_WORD_TWO: model_key.k2 = data;
         CSR_KEY_WORD_THREE: model_key.k3 = data;
         CSR_COMPLEMENT_MODE: model_complement = data[0];
         default: ;
      endcase
   endtask

   // Writes beyond the last register index must leave every register untouched.
   task automatic configure(input key_type key, input logic [WORD_WIDTH-1:0] mode_data);
      write_csr(CSR_KEY_WORD_ZERO, key.k0);
      write_csr(CSR_KEY_WORD_ONE, key.k1);
      write_csr(CSR_KEY_WORD_TWO, key.k2);
      write_csr(CSR_KEY_WORD_THREE, key.k3);
      write_csr(CSR_COMPLEMENT_MODE, mode_data);
      for (int k = 1; k <= 3; k++) begin
         write_csr(CSR_COMPLEMENT_MODE + CSR_INDEX_WIDTH'(k), $urandom);
      end
      csr_write_en <= 1'b0;
      setting_count++;
   endtask

   task automatic add_block(input logic cmd, input logic [WORD_WIDTH-1:0] left,
                            input logic [WORD_WIDTH-1:0] right, input logic last);
      block_item blk;
      blk.cmd = cmd;
      blk.left = left;
      blk.right = right;
      blk.last = last;
      blocks_to_send.push_back(blk);
   endtask

   // Most items form encrypt then decrypt pairs on the same block, so a round trip
   // through the cipher is exercised; the rest are unrelated blocks.
   task automatic queue_random(input int count);
      cipher_block           res;
      block_item             blk;
      logic [WORD_WIDTH-1:0] left;
      logic [WORD_WIDTH-1:0] right;
      int                    n;
      n = 0;
      while (n < count) begin
         left = $urandom;
         right = $urandom;
         if ($urandom_range(3) != 0) begin
            add_block(CMD_ENCRYPT, left, right, 1'($urandom_range(1)));
            blk.cmd = CMD_ENCRYPT;
            blk.left = left;
            blk.right = right;
            blk.last = 1'b0;
            res = tea_transform(blk);
            add_block(CMD_DECRYPT, res.left, res.right, 1'($urandom_range(1)));
            n += 2;
         end else begin
            add_block($urandom_range(1) ? CMD_DECRYPT : CMD_ENCRYPT, left, right,
                      1'($urandom_range(1)));
            n++;
         end
      end
   endtask

   task automatic wait_idle();
      while (blocks_to_send.size() != 0 || req_ch.valid || expected_blocks.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      queue_random(PHASE_ITEMS);
      wait_idle();
   endtask

   always @(posedge clock) begin : drive_blocks
      block_item blk;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            blk.cmd = req_ch.cmd;
            blk.left = req_ch.word_left;
            blk.right = req_ch.word_right;
            blk.last = req_ch.last_block;
            expected_blocks.push_back(tea_transform(blk));
            blocks_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (blocks_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               blk = blocks_to_send.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.cmd <= blk.cmd;
               req_ch.word_left <= blk.left;
               req_ch.word_right <= blk.right;
               req_ch.last_block <= blk.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      cipher_block exp_blk;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_blocks.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h_%h", rsp_ch.out_left,
                                         rsp_ch.out_right));
            end else begin
               exp_blk = expected_blocks.pop_front();
               if (rsp_ch.out_left !== exp_blk.left) begin
                  report_mismatch($sformatf("out_left %h, expected %h", rsp_ch.out_left,
                                            exp_blk.left));
               end
               if (rsp_ch.out_right !== exp_blk.right) begin
                  report_mismatch($sformatf("out_right %h, expected %h", rsp_ch.out_right,
                                            exp_blk.right));
               end
               if (rsp_ch.last_block_out !== exp_blk.last) begin
                  report_mismatch($sformatf("last_block_out %b, expected %b",
                                            rsp_ch.last_block_out, exp_blk.last));
               end
               blocks_checked++;
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_blocks.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      key_type key;
      clock = 1'b0;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_ENCRYPT;
      req_ch.word_left = '0;
      req_ch.word_right = '0;
      req_ch.last_block = 1'b0;
      rsp_ch.ready = 1'b0;
      model_key = '{KEY_WORD_ZERO_RESET, KEY_WORD_ONE_RESET, KEY_WORD_TWO_RESET,
                    KEY_WORD_THREE_RESET};
      model_complement = COMPLEMENT_MODE_RESET;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      blocks_sent = 0;
      blocks_checked = 0;
      error_count = 0;
      cycle_count = 0;
      setting_count = 1;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset key and complement mode, with extreme and patterned blocks.
      add_block(CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 1'b0);
      add_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      add_block(CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
      add_block(CMD_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
      add_block(CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 1'b1);
      add_block(CMD_ENCRYPT, 32'h0000_0001, 32'h8000_0000, 1'b0);
      add_block(CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000, 1'b1);
      add_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      add_block(CMD_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
      add_block(CMD_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
      add_block(CMD_DECRYPT, 32'h8000_0000, 32'h0000_0001, 1'b0);
      add_block(CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000, 1'b1);
      queue_random(10);
      wait_idle();

      configure('{$urandom, $urandom, $urandom, $urandom}, 32'h0);
      run_phase(0, 0);

      configure('0, 32'h1);
      run_phase(88, 0);

      // Only bit zero of a wide write reaches the complement mode register.
      configure('1, 32'hFFFF_FFFE);
      run_phase(0, 88);

      configure('{$urandom, $urandom, $urandom, $urandom}, $urandom | 32'h1);
      run_phase(18, 18);

      key = '{$urandom, $urandom, $urandom, $urandom};
      configure(key, $urandom);
      run_phase(0, 0);

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d of %0d blocks over %0d key and complement settings,",
               blocks_checked, blocks_sent, setting_count);
      $display("with encrypt and decrypt round trips under four flow patterns.");
      if (error_count == 0 && expected_blocks.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d results outstanding", error_count,
                  expected_blocks.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule
